// ===== sv/char_framebuffer_draw_engine_unit_macros.svh =====
// assertion macros for the character framebuffer draw engine
// included by modules that carry concurrent checks
`ifndef CHAR_FRAMEBUFFER_DRAW_ENGINE_UNIT_MACROS_SVH
`define CHAR_FRAMEBUFFER_DRAW_ENGINE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define CFD_ASSERT_IMP(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) else $error("lbl");
`define CFD_ASSERT_NXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) else $error("lbl");
`else
`define CFD_ASSERT_IMP(lbl, clk, rstn, a, c)
`define CFD_ASSERT_NXT(lbl, clk, rstn, a, c)
`endif
`endif

// ===== sv/cfde_pkg.sv =====
// types and constants for the character framebuffer draw engine
// no dependencies
package cfde_pkg;
  typedef enum logic [2:0] {
    OP_FILL = 3'd0, OP_SET = 3'd1, OP_LINE = 3'd2, OP_RECT = 3'd3, OP_READ = 3'd4
  } op_t;
  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_FILL, ST_LINE_DIV, ST_LINE_CELL, ST_VLINE,
    ST_RECT_H, ST_RECT_V, ST_READ_WAIT, ST_OUT
  } state_t;
  localparam logic [15:0] RESET_GLYPH = 16'd42;
  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;
endpackage

// ===== sv/cfde_if.sv =====
// valid/ready channel interfaces for the draw engine
// depends on nothing
interface cfde_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic [7:0] col_a;
  logic [7:0] row_a;
  logic [7:0] col_b;
  logic [7:0] row_b;
  logic [15:0] glyph;
  modport source (output valid, operation, col_a, row_a, col_b, row_b, glyph, input ready);
  modport sink (input valid, operation, col_a, row_a, col_b, row_b, glyph, output ready);
endinterface

interface cfde_res_if;
  logic        valid;
  logic        ready;
  logic [15:0] read_glyph;
  logic        status;
  modport source (output valid, read_glyph, status, input ready);
  modport sink (input valid, read_glyph, status, output ready);
endinterface

interface cfde_cfg_if;
  logic       valid;
  logic       ready;
  logic [0:0] index;
  logic [7:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/char_framebuffer_draw_engine_unit.sv =====
// Character-cell framebuffer draw engine, top level.
// Channels: in_ (command word), out_ (one result word per command), cfg_ (register
// writes: index 0 screen width, 1 screen height). All use valid/ready, a word moves
// when both are high.
// One command at a time. Cells live in one single-port ram (2**(CW+RW) words, row
// and column bits side by side) written at most one cell per cycle, so the ram port
// sets the pace of set, read, fill, vertical line and rectangle; a line with
// differing columns runs a serial divider for each column.
// The result sits in an output register until taken; while the receiver stalls no
// new command is accepted.
// After reset a clearing pass writes '*' into every ram word (MAX_COLS*MAX_ROWS
// of them for power-of-two sizes), during which in_ready is low;
// config writes are accepted at any time.
// Reset values: width 80, height 25.
`include "char_framebuffer_draw_engine_unit_macros.svh"
module char_framebuffer_draw_engine_unit
  import cfde_pkg::*;
#(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 64
) (
  input logic clk,
  input logic rst_n,
  cfde_cmd_if.sink   in_cmd,
  cfde_res_if.source out_res,
  cfde_cfg_if.sink   cfg
);
  localparam int CW = $clog2(MAX_COLS);
  localparam int RW = $clog2(MAX_ROWS);
  localparam int AW = CW + RW;
  localparam int DEPTH = 1 << AW;

  state_t state_r, state_nxt;
  logic [7:0] width_r;
  logic [6:0] height_r;
  logic [8:0] ucols;   // used columns 1..MAX_COLS
  logic [8:0] urows;
  logic [7:0] ca_r, ra_r, cb_r, rb_r;
  logic [15:0] glyph_r;
  logic [AW:0] clr_r, clr_nxt;
  logic [8:0] x_r, x_nxt, y_r, y_nxt, hi_r, hi_nxt;
  logic [15:0] rd_r, rd_nxt;
  logic st_r, st_nxt;
  logic side_r, side_nxt;
  // line divider
  logic signed [17:0] num_r;           // numerator, signed
  logic [8:0] den_r;                   // |x2-x1|
  logic den_neg_r;
  logic [17:0] quo_r, quo_nxt, rem_r, rem_nxt;
  logic [4:0] bit_r, bit_nxt;
  logic [17:0] absnum;
  logic [18:0] trial;
  logic signed [18:0] rowq;
  logic res_neg;

  logic we;
  logic [AW-1:0] addr;
  logic [15:0] wdata, rdata;

  cfde_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  always_comb begin
    ucols = (width_r == 8'd0) ? 9'd1 :
            ({1'b0, width_r} > 9'(MAX_COLS)) ? 9'(MAX_COLS) : {1'b0, width_r};
    urows = (height_r == 7'd0) ? 9'd1 :
            ({2'b0, height_r} > 9'(MAX_ROWS)) ? 9'(MAX_ROWS) : {2'b0, height_r};
  end

  function automatic logic onscr(input logic signed [19:0] x, input logic signed [19:0] y,
                                 input logic [8:0] uc, input logic [8:0] ur);
    onscr = (x >= 0) && (y >= 0) && (x < $signed({11'd0, uc})) && (y < $signed({11'd0, ur}));
  endfunction

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 8'd80;
      height_r <= 7'd25;
    end else if (cfg.valid) begin
      if (cfg.index == CFG_WIDTH) width_r <= cfg.data;
      else height_r <= cfg.data[6:0];
    end
  end

  assign in_cmd.ready  = (state_r == ST_IDLE);
  assign out_res.valid = (state_r == ST_OUT);
  assign out_res.read_glyph = rd_r;
  assign out_res.status = st_r;

  always_ff @(posedge clk) begin
    if (in_cmd.valid && in_cmd.ready) begin
      ca_r <= in_cmd.col_a;
      ra_r <= in_cmd.row_a;
      cb_r <= in_cmd.col_b;
      rb_r <= in_cmd.row_b;
      glyph_r <= in_cmd.glyph;
    end
  end

  always_comb begin
    absnum = num_r[17] ? 18'(-num_r) : 18'(num_r);
    trial  = {rem_r, absnum[bit_r]} - {10'd0, den_r};
    res_neg = num_r[17] ^ den_neg_r;
    rowq = res_neg ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
  end

  always_comb begin
    logic signed [19:0] sx, sy;
    logic [8:0] lo9;
    state_nxt = state_r;
    clr_nxt = clr_r;
    x_nxt = x_r; y_nxt = y_r; hi_nxt = hi_r;
    rd_nxt = rd_r; st_nxt = st_r; side_nxt = side_r;
    quo_nxt = quo_r; rem_nxt = rem_r; bit_nxt = bit_r;
    we = 1'b0; addr = '0; wdata = glyph_r;
    sx = '0; sy = '0; lo9 = '0;
    unique case (state_r)
      ST_CLEAR: begin
        we = 1'b1; wdata = RESET_GLYPH; addr = clr_r[AW-1:0];
        clr_nxt = clr_r + 1'b1;
        if (clr_r == (AW+1)'(DEPTH - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_cmd.valid) begin
          rd_nxt = '0; st_nxt = 1'b0;
          x_nxt = '0; y_nxt = '0; side_nxt = 1'b0;
          state_nxt = ST_OUT;
          case (in_cmd.operation)
            OP_FILL: state_nxt = ST_FILL;
            OP_SET: begin
              if (onscr({12'd0, in_cmd.col_a}, {12'd0, in_cmd.row_a}, ucols, urows)) begin
                we = 1'b1; wdata = in_cmd.glyph;
                addr = AW'({in_cmd.row_a[RW-1:0], in_cmd.col_a[CW-1:0]});
              end else st_nxt = 1'b1;
            end
            OP_READ: begin
              if (onscr({12'd0, in_cmd.col_a}, {12'd0, in_cmd.row_a}, ucols, urows)) begin
                addr = AW'({in_cmd.row_a[RW-1:0], in_cmd.col_a[CW-1:0]});
                state_nxt = ST_READ_WAIT;
              end else st_nxt = 1'b1;
            end
            OP_LINE: begin
              if (in_cmd.col_a != in_cmd.col_b) begin
                lo9 = (in_cmd.col_a < in_cmd.col_b) ? {1'b0, in_cmd.col_a} : {1'b0, in_cmd.col_b};
                hi_nxt = (in_cmd.col_a < in_cmd.col_b) ? {1'b0, in_cmd.col_b} : {1'b0, in_cmd.col_a};
                x_nxt = lo9;
                state_nxt = ST_LINE_DIV;
              end else begin
                y_nxt = (in_cmd.row_a < in_cmd.row_b) ? {1'b0, in_cmd.row_a} : {1'b0, in_cmd.row_b};
                hi_nxt = (in_cmd.row_a < in_cmd.row_b) ? {1'b0, in_cmd.row_b} : {1'b0, in_cmd.row_a};
                state_nxt = ST_VLINE;
              end
            end
            OP_RECT: begin
              x_nxt = {1'b0, in_cmd.col_a};
              y_nxt = {1'b0, in_cmd.row_a} + 9'd1;
              state_nxt = (in_cmd.col_a <= in_cmd.col_b) ? ST_RECT_H : ST_RECT_V;
            end
            default: ;
          endcase
          quo_nxt = '0; rem_nxt = '0; bit_nxt = 5'd18;
        end
      end
      ST_FILL: begin
        we = 1'b1;
        addr = AW'({y_r[RW-1:0], x_r[CW-1:0]});
        if (x_r == ucols - 9'd1) begin
          x_nxt = '0;
          y_nxt = y_r + 9'd1;
          if (y_r == urows - 9'd1) state_nxt = ST_OUT;
        end else x_nxt = x_r + 9'd1;
      end
      ST_LINE_DIV: begin
        // restoring division, one quotient bit per cycle; cycle of bit 18 loads numerator
        if (bit_r == 5'd31) begin
          state_nxt = ST_LINE_CELL;
        end else if (bit_r == 5'd18) begin
          bit_nxt = 5'd17;
        end else begin
          if (!trial[18]) begin
            rem_nxt = trial[17:0];
            quo_nxt = {quo_r[16:0], 1'b1};
          end else begin
            rem_nxt = {rem_r[16:0], absnum[bit_r]};
            quo_nxt = {quo_r[16:0], 1'b0};
          end
          bit_nxt = bit_r - 5'd1;
        end
      end
      ST_LINE_CELL: begin
        sx = {11'd0, x_r};
        sy = 20'(rowq);
        if (onscr(sx, sy, ucols, urows)) begin
          we = 1'b1;
          addr = AW'({sy[RW-1:0], x_r[CW-1:0]});
        end
        if (x_r == hi_r || x_r + 9'd1 >= ucols) state_nxt = ST_OUT;
        else begin
          x_nxt = x_r + 9'd1;
          quo_nxt = '0; rem_nxt = '0; bit_nxt = 5'd18;
          state_nxt = ST_LINE_DIV;
        end
      end
      ST_VLINE: begin
        if (onscr({12'd0, ca_r}, {11'd0, y_r}, ucols, urows)) begin
          we = 1'b1;
          addr = AW'({y_r[RW-1:0], ca_r[CW-1:0]});
        end
        if (y_r == hi_r || y_r + 9'd1 >= urows) state_nxt = ST_OUT;
        else y_nxt = y_r + 9'd1;
      end
      ST_RECT_H: begin
        sy = side_r ? {12'd0, rb_r} : {12'd0, ra_r};
        if (onscr({11'd0, x_r}, sy, ucols, urows)) begin
          we = 1'b1;
          addr = AW'({sy[RW-1:0], x_r[CW-1:0]});
        end
        if (side_r) begin
          side_nxt = 1'b0;
          if (x_r[7:0] == cb_r) state_nxt = ST_RECT_V;
          else x_nxt = x_r + 9'd1;
        end else side_nxt = 1'b1;
      end
      ST_RECT_V: begin
        sx = side_r ? {12'd0, cb_r} : {12'd0, ca_r};
        if ({1'b0, y_r} + 10'd1 > {2'b0, rb_r}) state_nxt = ST_OUT;
        else begin
          if (onscr(sx, {11'd0, y_r}, ucols, urows)) begin
            we = 1'b1;
            addr = AW'({y_r[RW-1:0], sx[CW-1:0]});
          end
          if (side_r) begin
            side_nxt = 1'b0;
            y_nxt = y_r + 9'd1;
          end else side_nxt = 1'b1;
        end
      end
      ST_READ_WAIT: begin
        rd_nxt = rdata;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_res.ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // line numerator for the current column, loaded before each division
  logic signed [9:0] dy, dxc, dden;
  always_comb begin
    dy   = $signed({2'b0, rb_r}) - $signed({2'b0, ra_r});
    dxc  = $signed({1'b0, x_r}) - $signed({2'b0, cb_r});
    dden = $signed({2'b0, cb_r}) - $signed({2'b0, ca_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r <= '0;
      x_r <= '0; y_r <= '0; hi_r <= '0;
      side_r <= 1'b0; st_r <= 1'b0; rd_r <= '0; bit_r <= 5'd18;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      x_r <= x_nxt; y_r <= y_nxt; hi_r <= hi_nxt;
      side_r <= side_nxt; st_r <= st_nxt; rd_r <= rd_nxt;
      bit_r <= bit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= dden[9] ? 9'(-dden) : 9'(dden);
    den_neg_r <= dden[9];
    // y2*den + dy*dxc, products of narrow values
    num_r <= 18'($signed({2'b0, rb_r}) * dden + dy * dxc);
  end

  `CFD_ASSERT_IMP(a_no_accept_busy, clk, rst_n, state_r != ST_IDLE, !in_cmd.ready)
  `CFD_ASSERT_NXT(a_cmd_to_work, clk, rst_n, in_cmd.valid && in_cmd.ready, state_r != ST_IDLE)
  `CFD_ASSERT_IMP(a_no_write_out, clk, rst_n, state_r == ST_OUT, !we)
  `CFD_ASSERT_NXT(a_out_done, clk, rst_n, out_res.valid && out_res.ready, state_r == ST_IDLE)
endmodule

// ===== sv/cfde_ram.sv =====
// generic single-port ram with registered read
// no dependencies
module cfde_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// ===== verif/cfde_checker.sv =====
// result checker for the character framebuffer draw engine
// depends on cfde_pkg and the channel interfaces in cfde_if.sv
`timescale 1ns / 100ps
module cfde_checker
  import cfde_pkg::*;
#(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 64
) (
  input  logic clk,
  input  logic rst_n,
  cfde_cmd_if.sink cmd_mon,
  cfde_res_if.sink res_mon,
  cfde_cfg_if.sink cfg_mon,
  output int       fail_count,
  output int       pending
);
  typedef struct packed {
    logic [15:0] read_glyph;
    logic        status;
  } outcome_t;

  logic [15:0] cells [MAX_COLS*MAX_ROWS];
  logic [7:0]  width_reg;
  logic [6:0]  height_reg;
  outcome_t    outcomes [$];

  function automatic int cols_used();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_COLS) return MAX_COLS;
    return width_reg;
  endfunction

  function automatic int rows_used();
    if (height_reg == 0) return 1;
    if (height_reg > MAX_ROWS) return MAX_ROWS;
    return height_reg;
  endfunction

  function automatic bit visible(longint x, longint y);
    return x >= 0 && y >= 0 && x < cols_used() && y < rows_used();
  endfunction

  function automatic void plot(longint x, longint y, logic [15:0] g);
    if (visible(x, y)) cells[y*MAX_COLS + x] = g;
  endfunction

  function automatic outcome_t draw(op_t op, longint ca, longint ra, longint cb,
                                    longint rb, logic [15:0] g);
    outcome_t r;
    longint den, lo, hi, x, y;
    r = '0;
    case (op)
      OP_FILL: begin
        for (y = 0; y < rows_used(); y++)
          for (x = 0; x < cols_used(); x++) cells[y*MAX_COLS + x] = g;
      end
      OP_SET: begin
        if (visible(ca, ra)) plot(ca, ra, g);
        else r.status = 1'b1;
      end
      OP_LINE: begin
        if (ca != cb) begin
          den = cb - ca;
          lo = ca < cb ? ca : cb;
          hi = ca < cb ? cb : ca;
          for (x = lo; x <= hi && x < cols_used(); x++) begin
            y = (rb*den + (rb - ra)*(x - cb)) / den;
            if (y >= 0 && y < rows_used()) plot(x, y, g);
          end
        end else begin
          lo = ra < rb ? ra : rb;
          hi = ra < rb ? rb : ra;
          for (y = lo; y <= hi && y < rows_used(); y++) plot(ca, y, g);
        end
      end
      OP_RECT: begin
        for (x = ca; x <= cb; x++) begin
          plot(x, ra, g);
          plot(x, rb, g);
        end
        for (y = ra + 1; y <= rb - 1; y++) begin
          plot(ca, y, g);
          plot(cb, y, g);
        end
      end
      OP_READ: begin
        if (visible(ca, ra)) r.read_glyph = cells[ra*MAX_COLS + ca];
        else r.status = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  assign pending = outcomes.size();

  always @(posedge clk) begin
    outcome_t want;
    int errs;
    errs = 0;
    if (!rst_n) begin
      for (int i = 0; i < MAX_COLS*MAX_ROWS; i++) cells[i] = RESET_GLYPH;
      width_reg  <= 8'd80;
      height_reg <= 7'd25;
      outcomes.delete();
      fail_count <= 0;
    end else begin
      if (res_mon.valid && res_mon.ready) begin
        if (outcomes.size() == 0) begin
          $error("result word with nothing expected");
          errs++;
        end else begin
          want = outcomes.pop_front();
          if (res_mon.read_glyph !== want.read_glyph) begin
            $error("read_glyph: expected %h, got %h", want.read_glyph, res_mon.read_glyph);
            errs++;
          end
          if (res_mon.status !== want.status) begin
            $error("status: expected %b, got %b", want.status, res_mon.status);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count <= fail_count + errs;
      if (cmd_mon.valid && cmd_mon.ready)
        outcomes.push_back(draw(op_t'(cmd_mon.operation), cmd_mon.col_a, cmd_mon.row_a,
                                cmd_mon.col_b, cmd_mon.row_b, cmd_mon.glyph));
      if (cfg_mon.valid && cfg_mon.ready) begin
        if (cfg_mon.index == CFG_WIDTH) width_reg <= cfg_mon.data;
        else height_reg <= cfg_mon.data[6:0];
      end
    end
  end
endmodule

// ===== verif/tb_char_framebuffer_draw_engine_unit.sv =====
// stimulus and verdict for the character framebuffer draw engine
// depends on cfde_pkg, cfde_if.sv, cfde_checker.sv and the block itself
`timescale 1ns / 100ps
module tb_char_framebuffer_draw_engine_unit;
  import cfde_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count, pending;
  int   cycles = 0;
  bit   hold_off = 1'b0;

  cfde_cmd_if in_cmd ();
  cfde_res_if out_res ();
  cfde_cfg_if cfg ();

  always #5 clk = ~clk;

  char_framebuffer_draw_engine_unit dut (
    .clk(clk), .rst_n(rst_n), .in_cmd(in_cmd), .out_res(out_res), .cfg(cfg)
  );

  cfde_checker chk (
    .clk(clk), .rst_n(rst_n), .cmd_mon(in_cmd), .res_mon(out_res), .cfg_mon(cfg),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    in_cmd.valid = 1'b0;
    in_cmd.operation = '0;
    in_cmd.col_a = '0;
    in_cmd.row_a = '0;
    in_cmd.col_b = '0;
    in_cmd.row_b = '0;
    in_cmd.glyph = '0;
    out_res.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
  end

  // cycle limit: clearing pass plus slow fills and lines under stall
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 1500000) begin
      $display("tb_char_framebuffer_draw_engine_unit: done, errors");
      $finish;
    end
  end

  // receiver with random stalls and one long hold-off
  initial begin
    int wait_n;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_off) begin
        out_res.ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
      if (wait_n > 0) begin
        out_res.ready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      out_res.ready <= 1'b1;
      @(posedge clk);
      while (!(out_res.valid && out_res.ready)) @(posedge clk);
    end
  end

  // valid stays high after a word so that the next one can follow directly
  task automatic send_word(op_t op, logic [7:0] ca, logic [7:0] ra, logic [7:0] cb,
                           logic [7:0] rb, logic [15:0] g, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_cmd.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_cmd.valid <= 1'b1;
    in_cmd.operation <= op;
    in_cmd.col_a <= ca;
    in_cmd.row_a <= ra;
    in_cmd.col_b <= cb;
    in_cmd.row_b <= rb;
    in_cmd.glyph <= g;
    @(posedge clk);
    while (!in_cmd.ready) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [7:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_cmd.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // random coordinate, mostly near the in-use area
  function automatic logic [7:0] coord(int span);
    return ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, span));
  endfunction

  task automatic random_words(int n, int w, int h);
    op_t op;
    logic [2:0] code;
    for (int i = 0; i < n; i++) begin
      code = $urandom_range(0, 19) == 0 ? 3'($urandom_range(5, 7)) :
             ($urandom_range(0, 12) == 0 ? OP_FILL : 3'($urandom_range(1, 4)));
      op = op_t'(code);
      send_word(op, coord(w + 2), coord(h + 2), coord(w + 2), coord(h + 2), 16'($urandom));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: default 80x25 screen
    send_word(OP_READ, 0, 0, 0, 0, 0);
    send_word(OP_SET, 0, 0, 0, 0, 16'hFFFF);
    send_word(OP_READ, 0, 0, 0, 0, 0);
    send_word(OP_SET, 79, 24, 0, 0, 16'h0000);
    send_word(OP_SET, 80, 3, 0, 0, 16'h1234);
    send_word(OP_READ, 3, 25, 0, 0, 0);
    send_word(OP_READ, 255, 255, 0, 0, 0);
    send_word(OP_LINE, 0, 0, 79, 24, 16'hAAAA);
    send_word(OP_LINE, 70, 30, 5, 255, 16'h5555);
    send_word(OP_LINE, 10, 20, 10, 2, 16'h0101);
    send_word(OP_LINE, 200, 0, 200, 255, 16'h0202);
    send_word(OP_RECT, 5, 2, 60, 20, 16'h0303);
    send_word(OP_RECT, 60, 4, 5, 12, 16'h0404);
    send_word(OP_RECT, 3, 7, 9, 8, 16'h0505);
    send_word(OP_RECT, 70, 20, 255, 255, 16'h0606);
    send_word(op_t'(3'd5), 1, 1, 1, 1, 16'h7777);
    send_word(op_t'(3'd7), 255, 255, 255, 255, 16'hFFFF);
    send_word(OP_READ, 10, 10, 0, 0, 0);
    // fill up while receiver holds off
    hold_off = 1'b1;
    for (int i = 0; i < 6; i++) send_word(OP_SET, i, i, 0, 0, 16'(i), 1);
    random_words(20, 80, 25);
    drain();
    // extremes of the registers: zero width/height, then the maximum and beyond
    write_reg(CFG_WIDTH, 8'd0);
    write_reg(CFG_HEIGHT, 8'd0);
    send_word(OP_FILL, 0, 0, 0, 0, 16'h00F0);
    send_word(OP_READ, 0, 0, 0, 0, 0);
    send_word(OP_READ, 1, 0, 0, 0, 0);
    random_words(8, 3, 3);
    drain();
    write_reg(CFG_WIDTH, 8'd255);
    write_reg(CFG_HEIGHT, 8'd127);
    send_word(OP_READ, 127, 63, 0, 0, 0);
    send_word(OP_FILL, 0, 0, 0, 0, 16'h8001);
    send_word(OP_LINE, 127, 63, 0, 0, 16'h4242);
    random_words(20, 128, 64);
    drain();
    write_reg(CFG_WIDTH, 8'd128);
    write_reg(CFG_HEIGHT, 8'd64);
    random_words(12, 128, 64);
    drain();
    write_reg(CFG_WIDTH, 8'd17);
    write_reg(CFG_HEIGHT, 8'd9);
    random_words(20, 17, 9);
    drain();
    if (fail_count == 0)
      $display("tb_char_framebuffer_draw_engine_unit: done, clean");
    else
      $display("tb_char_framebuffer_draw_engine_unit: done, errors");
    $finish;
  end
endmodule
